[src/bb3_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_pkg
// shared constants, codes and controller/datapath handshake types for the
// 3x3 edge-clipped box blur
// ----------------------------------------------------------------------------
package bb3_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam int PIX_W    = 8;
	localparam int RGB_W    = 3 * PIX_W;
	localparam int NUM_CH   = 3;
	localparam int CFG_DW   = 11;
	localparam int CFG_IW   = 1;
	localparam int SUM_W    = 12;
	localparam int CNT_W    = 4;
	localparam int MEAN_DDW = 13;
	localparam int MEAN_DVW = 5;

	localparam logic [CFG_DW-1:0] RESET_WIDTH  = CFG_DW'(640);
	localparam logic [CFG_DW-1:0] RESET_HEIGHT = CFG_DW'(480);

	localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic REQ_PIXEL = 1'b0;
	localparam logic REQ_FLUSH = 1'b1;

	typedef enum logic {
		DIV_POS  = 1'b0,
		DIV_MEAN = 1'b1
	} div_sel_t;

	typedef struct packed {
		logic     accept;
		logic     pre;
		logic     win;
		logic     chk;
		logic     div_start;
		div_sel_t div_sel;
		logic     pos_done;
		logic     sum;
		logic     mean_done;
		logic     load_out;
	} bb3_cmd_t;

	typedef struct packed {
		logic skip;
		logic emit;
		logic over;
		logic div_done;
		logic ch_last;
		logic out_free;
	} bb3_sts_t;

endpackage
`default_nettype wire

[src/bb3_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module bb3_div #(
	parameter int DDW = 20,
	parameter int DVW = 11
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	input  wire logic [DDW-1:0] dividend,
	input  wire logic [DVW-1:0] divisor,
	output logic                done,
	output logic      [DDW-1:0] quotient,
	output logic      [DVW-1:0] remainder
);
	localparam int IW = (DDW > 1) ? $clog2(DDW) : 1;

	logic [DDW-1:0] quo_q;
	logic [DVW-1:0] rem_q;
	logic [DVW-1:0] dvs_q;
	logic [IW-1:0]  cnt_q;
	logic           busy_q;
	logic           done_q;
	logic [DVW:0]   trial;
	logic           fits;

	assign trial = {rem_q, quo_q[DDW-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == IW'(DDW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= DVW'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[DVW-1:0];
			end
			quo_q <= {quo_q[DDW-2:0], fits};
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule
`default_nettype wire

[src/bb3_dp.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_dp
// datapath: config registers, line stores, 3x3 window, counters, divider,
// and output register
// ----------------------------------------------------------------------------
module bb3_dp #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_write,
	input  wire logic [bb3_pkg::CFG_IW-1:0]  cfg_index,
	input  wire logic [bb3_pkg::CFG_DW-1:0]  cfg_data,
	input  wire logic                        req_type,
	input  wire logic [bb3_pkg::PIX_W-1:0]   pixel_red,
	input  wire logic [bb3_pkg::PIX_W-1:0]   pixel_green,
	input  wire logic [bb3_pkg::PIX_W-1:0]   pixel_blue,
	input  wire logic                        out_stall,
	output logic                             out_valid,
	output logic      [bb3_pkg::PIX_W-1:0]   blur_red,
	output logic      [bb3_pkg::PIX_W-1:0]   blur_green,
	output logic      [bb3_pkg::PIX_W-1:0]   blur_blue,
	output logic                             frame_last,
	input  wire bb3_pkg::bb3_cmd_t           cmd,
	output bb3_pkg::bb3_sts_t                sts
);
	import bb3_pkg::*;

	localparam int WW  = $clog2(MAX_WIDTH + 1);
	localparam int HW  = $clog2(MAX_HEIGHT + 1);
	localparam int RW  = HW + 1;
	localparam int PW  = WW + HW;
	localparam int AW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int DDW = (PW > MEAN_DDW) ? PW : MEAN_DDW;
	localparam int DVW = (WW > MEAN_DVW) ? WW : MEAN_DVW;

	logic [CFG_DW-1:0] width_q, height_q;
	logic [WW-1:0]     w_eff;
	logic [HW-1:0]     h_eff;
	logic [PW-1:0]     wh_q;

	logic              req_q;
	logic [RGB_W-1:0]  pix_q;

	logic [RGB_W-1:0]  upper_mem [MAX_WIDTH];
	logic [RGB_W-1:0]  lower_mem [MAX_WIDTH];
	logic [RGB_W-1:0]  top_q, mid_q;
	logic [RGB_W-1:0]  win_q [9];
	logic [RGB_W-1:0]  newv;

	logic [WW-1:0]     col_q, col_wrap, col_inc;
	logic [RW-1:0]     row_q;
	logic [PW-1:0]     pos_q;
	logic [HW-1:0]     cr_q;
	logic [WW-1:0]     cc_q;
	logic              do_clear;

	logic [SUM_W-1:0]  sum_q [NUM_CH];
	logic [SUM_W-1:0]  sum_c [NUM_CH];
	logic [CNT_W-1:0]  cnt_q, cnt_c;
	logic [2:0]        rv, cv;
	logic [1:0]        ch_q;
	logic [PIX_W-1:0]  mean_q [NUM_CH];
	logic              last_q;

	logic [DDW-1:0]    div_dd;
	logic [DVW-1:0]    div_dv;
	logic              div_done;
	logic [DDW-1:0]    div_quo;
	logic [DVW-1:0]    div_rem;

	logic              out_valid_q, frame_last_q;
	logic [PIX_W-1:0]  out_r_q, out_g_q, out_b_q;

	// clamp registers to the supported range
	assign w_eff = (width_q == '0) ? WW'(1) :
		((32'(width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(width_q));
	assign h_eff = (height_q == '0) ? HW'(1) :
		((32'(height_q) > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(height_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= cfg_data;
				REG_IMAGE_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		wh_q <= PW'(w_eff) * PW'(h_eff);
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req_type;
			pix_q <= {pixel_red, pixel_green, pixel_blue};
		end
	end

	assign col_wrap = (col_q >= w_eff) ? '0 : col_q;
	assign col_inc  = col_q + 1'b1;
	assign newv     = (req_q == REQ_FLUSH) ? '0 : pix_q;

	assign sts.skip = (req_q == REQ_FLUSH) && (row_q < RW'(h_eff));
	assign sts.emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
	assign sts.over = (pos_q >= wh_q);

	// line stores, registered read at the current column
	always_ff @(posedge clk) begin
		top_q <= upper_mem[col_q[AW-1:0]];
		mid_q <= lower_mem[col_q[AW-1:0]];
		if (cmd.win) begin
			upper_mem[col_q[AW-1:0]] <= mid_q;
			lower_mem[col_q[AW-1:0]] <= newv;
		end
	end

	assign do_clear = (cmd.pre && (req_q == REQ_PIXEL) && (row_q >= RW'(h_eff)))
		|| (cmd.chk && sts.over)
		|| (cmd.sum && (pos_q == wh_q - 1'b1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else if (do_clear) begin
			col_q <= '0;
			row_q <= '0;
			pos_q <= '0;
			for (int i = 0; i < 9; i++) win_q[i] <= '0;
		end else begin
			if (cmd.pre) col_q <= col_wrap;
			if (cmd.win) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]   <= win_q[r*3+1];
					win_q[r*3+1] <= win_q[r*3+2];
				end
				win_q[2] <= top_q;
				win_q[5] <= mid_q;
				win_q[8] <= newv;
				if (col_inc >= w_eff) begin
					col_q <= '0;
					row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc;
				end
			end
			if (cmd.sum) pos_q <= pos_q + 1'b1;
		end
	end

	// shared divider: output position, then the three channel means
	always_comb begin
		if (cmd.div_sel == DIV_POS) begin
			div_dd = DDW'(pos_q);
			div_dv = DVW'(w_eff);
		end else begin
			div_dd = DDW'({sum_q[ch_q], 1'b0}) + DDW'(cnt_q);
			div_dv = DVW'({cnt_q, 1'b0});
		end
	end

	bb3_div #(
		.DDW(DDW),
		.DVW(DVW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dd),
		.divisor  (div_dv),
		.done     (div_done),
		.quotient (div_quo),
		.remainder(div_rem)
	);

	assign sts.div_done = div_done;
	assign sts.ch_last  = (ch_q == 2'(NUM_CH - 1));

	always_ff @(posedge clk) begin
		if (cmd.pos_done) begin
			cr_q <= div_quo[HW-1:0];
			cc_q <= div_rem[WW-1:0];
		end
	end

	// cells outside the image are masked
	always_comb begin
		rv[0] = (cr_q != '0);
		rv[1] = 1'b1;
		rv[2] = ((PW'(cr_q) + 1'b1) < PW'(h_eff));
		cv[0] = (cc_q != '0);
		cv[1] = 1'b1;
		cv[2] = ((PW'(cc_q) + 1'b1) < PW'(w_eff));
		cnt_c = '0;
		for (int ch = 0; ch < NUM_CH; ch++) sum_c[ch] = '0;
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				if (rv[r] && cv[c]) begin
					cnt_c = cnt_c + 1'b1;
					for (int ch = 0; ch < NUM_CH; ch++) begin
						sum_c[ch] = sum_c[ch] +
							SUM_W'(win_q[r*3+c][RGB_W-1-PIX_W*ch -: PIX_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q <= '0;
		end else if (cmd.sum) begin
			ch_q <= '0;
		end else if (cmd.mean_done && !sts.ch_last) begin
			ch_q <= ch_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sum) begin
			for (int ch = 0; ch < NUM_CH; ch++) sum_q[ch] <= sum_c[ch];
			cnt_q  <= cnt_c;
			last_q <= (pos_q == wh_q - 1'b1);
		end
		if (cmd.mean_done) mean_q[ch_q] <= div_quo[PIX_W-1:0];
	end

	// output register
	assign sts.out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_r_q      <= mean_q[0];
			out_g_q      <= mean_q[1];
			out_b_q      <= mean_q[2];
			frame_last_q <= last_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign blur_red   = out_r_q;
	assign blur_green = out_g_q;
	assign blur_blue  = out_b_q;
	assign frame_last = frame_last_q;

endmodule
`default_nettype wire

[src/bb3_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bb3_ctrl
// controller: sequences one request at a time through the datapath
// ----------------------------------------------------------------------------
module bb3_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire bb3_pkg::bb3_sts_t   sts,
	output bb3_pkg::bb3_cmd_t        cmd
);
	import bb3_pkg::*;

	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_PRE   = 11'b000_0000_0010,
		S_RD    = 11'b000_0000_0100,
		S_WIN   = 11'b000_0000_1000,
		S_CHK   = 11'b000_0001_0000,
		S_POS   = 11'b000_0010_0000,
		S_POSW  = 11'b000_0100_0000,
		S_SUM   = 11'b000_1000_0000,
		S_MEAN  = 11'b001_0000_0000,
		S_MEANW = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} state_t;

	state_t st_q, st_d;

	assign in_stall = (st_q != S_IDLE);

	always_comb begin
		st_d = st_q;
		cmd  = '0;
		cmd.div_sel = DIV_POS;
		case (st_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					st_d = S_PRE;
				end
			end
			S_PRE: begin
				cmd.pre = 1'b1;
				st_d = sts.skip ? S_IDLE : S_RD;
			end
			S_RD: st_d = S_WIN;
			S_WIN: begin
				cmd.win = 1'b1;
				st_d = sts.emit ? S_CHK : S_IDLE;
			end
			S_CHK: begin
				cmd.chk = 1'b1;
				st_d = sts.over ? S_IDLE : S_POS;
			end
			S_POS: begin
				cmd.div_start = 1'b1;
				st_d = S_POSW;
			end
			S_POSW: begin
				if (sts.div_done) begin
					cmd.pos_done = 1'b1;
					st_d = S_SUM;
				end
			end
			S_SUM: begin
				cmd.sum = 1'b1;
				st_d = S_MEAN;
			end
			S_MEAN: begin
				cmd.div_sel   = DIV_MEAN;
				cmd.div_start = 1'b1;
				st_d = S_MEANW;
			end
			S_MEANW: begin
				cmd.div_sel = DIV_MEAN;
				if (sts.div_done) begin
					cmd.mean_done = 1'b1;
					st_d = sts.ch_last ? S_FIN : S_MEAN;
				end
			end
			S_FIN: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					st_d = S_IDLE;
				end
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

endmodule
`default_nettype wire

[src/box_blur_3x3_edge_clipped.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_edge_clipped
// streaming 3x3 box blur of an RGB raster image, edges clipped
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with req_type and the pixel; send pixels in
// raster order, then image_width + 1 flush requests to drain the last row.
// output channel: out_valid/out_stall with the three means and frame_last.
// config: cfg_write/cfg_index/cfg_data, index 0 width, 1 height; write only
// while no request is in flight.
// one request is handled at a time. a request with a result runs four
// divisions on the shared bit-serial divider, whose dividend width is 22 at
// the default 1024 x 1024 size: one division for the output row and column,
// three for the channel means.
// results appear one row plus one pixel behind the pixels that cause them.
// a finished result sits in the output register; the next request is taken
// while it waits, and the block only holds at the end of the following
// request if the receiver still stalls.
// reset clears the counters, window and output valid; registers return to
// 640 x 480; line stores are not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_edge_clipped #(
	parameter int MAX_WIDTH  = bb3_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = bb3_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_write,
	input  wire logic [bb3_pkg::CFG_IW-1:0] cfg_index,
	input  wire logic [bb3_pkg::CFG_DW-1:0] cfg_data,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic                       req_type,
	input  wire logic [bb3_pkg::PIX_W-1:0]  pixel_red,
	input  wire logic [bb3_pkg::PIX_W-1:0]  pixel_green,
	input  wire logic [bb3_pkg::PIX_W-1:0]  pixel_blue,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic      [bb3_pkg::PIX_W-1:0]  blur_red,
	output logic      [bb3_pkg::PIX_W-1:0]  blur_green,
	output logic      [bb3_pkg::PIX_W-1:0]  blur_blue,
	output logic                            frame_last
);
	import bb3_pkg::*;

	bb3_cmd_t cmd;
	bb3_sts_t sts;

	bb3_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	bb3_dp #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.req_type   (req_type),
		.pixel_red  (pixel_red),
		.pixel_green(pixel_green),
		.pixel_blue (pixel_blue),
		.out_stall  (out_stall),
		.out_valid  (out_valid),
		.blur_red   (blur_red),
		.blur_green (blur_green),
		.blur_blue  (blur_blue),
		.frame_last (frame_last),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule
`default_nettype wire
